// File: src/mlp_pkg.sv
// shared constants and helpers for the mlp relu inference core
// no dependencies
package mlp_pkg;

    localparam int MaxLayers = 4;
    localparam int MaxWidth  = 16;
    localparam int DataWidth = 32;

    localparam int LayerBits = $clog2(MaxLayers);
    localparam int RowBits   = $clog2(MaxWidth);
    localparam int WAddrBits = LayerBits + 2 * RowBits;
    localparam int BAddrBits = LayerBits + RowBits;
    localparam int AccBits   = 64;

    localparam logic [1:0] ActWeight  = 2'd0;
    localparam logic [1:0] ActBias    = 2'd1;
    localparam logic [1:0] ActFeature = 2'd2;

    localparam logic [2:0] CfgLayerCount = 3'd0;
    localparam logic [2:0] CfgInputCount = 3'd1;
    localparam logic [2:0] CfgWidth0     = 3'd2;
    localparam logic [2:0] CfgWidth3     = 3'd5;

    // clamp a 5-bit count into 1..MaxWidth
    function automatic logic [4:0] clamp_width(input logic [4:0] v);
        logic [4:0] r;
        begin
            if (v == 5'd0) r = 5'd1;
            else if (v > 5'(MaxWidth)) r = 5'(MaxWidth);
            else r = v;
            return r;
        end
    endfunction

    function automatic logic [2:0] clamp_layers(input logic [2:0] v);
        logic [2:0] r;
        begin
            if (v == 3'd0) r = 3'd1;
            else if (v > 3'(MaxLayers)) r = 3'(MaxLayers);
            else r = v;
            return r;
        end
    endfunction

endpackage

// File: src/mlp_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
module mlp_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/mlp_relu_inference_core.sv
// mlp relu inference core: weight/bias stores, activation ping-pong, one shared mac
// depends on mlp_pkg and mlp_ram
//
// channel   direction  ports
// command   in         i_start / o_busy, i_action .. i_final_feature
// result    out        o_valid, o_neuron_index, o_result_value, o_last
// config    in         i_cfg_we, i_cfg_index, i_cfg_data
//
// loads and non-final features are simply stored; a final feature runs the pass
// on one multiplier over every layer and then outputs the results one by one;
// busy stays high until the last result.
// synchronous active-low reset; the activation buffers are cleared by a
// sweep over all 16 entries after reset, during which busy is high.
// results cannot be stalled: each is shown for one cycle with o_valid.
module mlp_relu_inference_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_action,
    input  logic [1:0]  i_layer_index,
    input  logic [3:0]  i_row_index,
    input  logic [3:0]  i_col_index,
    input  logic signed [31:0] i_value,
    input  logic        i_final_feature,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    output logic        o_valid,
    output logic [3:0]  o_neuron_index,
    output logic signed [31:0] o_result_value,
    output logic        o_last
);
    localparam int RB = mlp_pkg::RowBits;
    localparam int LB = mlp_pkg::LayerBits;
    localparam int DW = mlp_pkg::DataWidth;
    localparam int AB = mlp_pkg::AccBits;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_MAC, S_BIAS, S_WRITE, S_OUT
    } t_state;

    t_state r_state;
    logic [2:0] r_layer_count;
    logic [4:0] r_input_count;
    logic [4:0] r_width [mlp_pkg::MaxLayers];

    logic [LB-1:0] r_l;
    logic [RB:0]   r_i;       // output row, wide enough to hold the width
    logic [RB:0]   r_j;       // input column
    logic [RB:0]   r_n_in;
    logic [RB:0]   r_n_out;
    logic          r_cur;
    logic          r_pend;    // product register holds a valid term
    logic signed [AB-1:0] r_acc;
    logic signed [AB-1:0] r_prod;
    logic signed [DW-1:0] r_act [2][mlp_pkg::MaxWidth];

    // store ports
    logic                       w_we, b_we;
    logic [mlp_pkg::WAddrBits-1:0] w_waddr, w_raddr;
    logic [mlp_pkg::BAddrBits-1:0] b_waddr, b_raddr;
    logic [DW-1:0] w_rdata, b_rdata;

    logic accept;
    assign accept = i_start && !o_busy;
    assign w_we = accept && (i_action == mlp_pkg::ActWeight);
    assign b_we = accept && (i_action == mlp_pkg::ActBias);
    assign w_waddr = {i_layer_index, i_row_index, i_col_index};
    assign b_waddr = {i_layer_index, i_row_index};
    assign w_raddr = {r_l, r_i[RB-1:0], r_j[RB-1:0]};
    assign b_raddr = {r_l, r_i[RB-1:0]};

    mlp_ram #(.Width(DW), .Depth(1 << mlp_pkg::WAddrBits)) u_wram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_value),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );
    mlp_ram #(.Width(DW), .Depth(1 << mlp_pkg::BAddrBits)) u_bram (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(i_value),
        .i_raddr(b_raddr), .o_rdata(b_rdata)
    );

    // activation tap registered alongside the weight read
    logic signed [DW-1:0] r_a;
    // product floored to q16.16 by arithmetic shift
    logic signed [AB-1:0] prod_full;
    assign prod_full = $signed(w_rdata) * r_a;

    logic signed [AB-1:0] sum_b;
    logic signed [DW-1:0] sat_v, relu_v;
    localparam logic signed [AB-1:0] SatHi = AB'((64'sd1 <<< (DW - 1)) - 1);
    localparam logic signed [AB-1:0] SatLo = -SatHi - 1;
    assign sum_b = r_acc + AB'($signed(b_rdata));
    always_comb begin
        if (sum_b > SatHi) sat_v = DW'(SatHi);
        else if (sum_b < SatLo) sat_v = DW'(SatLo);
        else sat_v = sum_b[DW-1:0];
        relu_v = (r_n_out != (RB+1)'(1) && sat_v < 0) ? '0 : sat_v;
    end

    logic [RB:0] last_layer;
    assign last_layer = (RB+1)'(mlp_pkg::clamp_layers(r_layer_count)) - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_layer_count <= 3'd1;
            r_input_count <= 5'd2;
            for (int k = 0; k < mlp_pkg::MaxLayers; k++) r_width[k] <= 5'd1;
            r_i <= '0;
            r_j <= '0;
            r_l <= '0;
            r_cur <= 1'b0;
            r_pend <= 1'b0;
            o_valid <= 1'b0;
            o_last <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            o_last <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == mlp_pkg::CfgLayerCount) r_layer_count <= i_cfg_data[2:0];
                else if (i_cfg_index == mlp_pkg::CfgInputCount) r_input_count <= i_cfg_data;
                else if (i_cfg_index >= mlp_pkg::CfgWidth0
                         && i_cfg_index <= mlp_pkg::CfgWidth3)
                    r_width[LB'(i_cfg_index - mlp_pkg::CfgWidth0)] <= i_cfg_data;
            end
            case (r_state)
                S_CLEAR: begin
                    r_act[0][r_i[RB-1:0]] <= '0;
                    r_act[1][r_i[RB-1:0]] <= '0;
                    r_i <= r_i + 1'b1;
                    if (r_i == (RB+1)'(mlp_pkg::MaxWidth - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && i_action == mlp_pkg::ActFeature) begin
                        r_act[0][i_col_index] <= i_value;
                        if (i_final_feature) begin
                            r_l <= '0;
                            r_i <= '0;
                            r_j <= '0;
                            r_cur <= 1'b0;
                            r_n_in <= mlp_pkg::clamp_width(r_input_count);
                            r_n_out <= mlp_pkg::clamp_width(r_width[0]);
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // start a row: issue first weight read
                    r_acc <= '0;
                    r_pend <= 1'b0;
                    r_a <= r_act[r_cur][r_j[RB-1:0]];
                    r_j <= r_j + 1'b1;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    // weight for previous column arrives; one multiply per cycle
                    r_prod <= prod_full >>> 16;
                    r_pend <= 1'b1;
                    if (r_pend) r_acc <= r_acc + r_prod;
                    if (r_j == r_n_in) begin
                        r_state <= S_BIAS;
                    end else begin
                        r_a <= r_act[r_cur][r_j[RB-1:0]];
                        r_j <= r_j + 1'b1;
                    end
                end
                S_BIAS: begin
                    // fold the last product; bias read is ready
                    r_acc <= r_acc + r_prod;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_act[~r_cur][r_i[RB-1:0]] <= relu_v;
                    r_j <= '0;
                    if (r_i + 1'b1 == r_n_out) begin
                        r_i <= '0;
                        if ((RB+1)'(r_l) == last_layer) begin
                            r_cur <= ~r_cur;
                            r_state <= S_OUT;
                        end else begin
                            r_l <= r_l + 1'b1;
                            r_cur <= ~r_cur;
                            r_n_in <= r_n_out;
                            r_n_out <= mlp_pkg::clamp_width(r_width[r_l + 1'b1]);
                            r_state <= S_READ;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    o_neuron_index <= r_i[RB-1:0];
                    o_result_value <= r_act[r_cur][r_i[RB-1:0]];
                    o_last <= (r_i + 1'b1 == r_n_out);
                    r_i <= r_i + 1'b1;
                    if (r_i + 1'b1 == r_n_out) begin
                        r_i <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // results only leave while the pass is running
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy)) else $error("result outside a pass");
    // last marks the end of the output burst
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !o_busy) else $error("busy after last result");
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid) else $error("last without valid");
endmodule
